/* sv/srnc_pkg.sv */
// Package for the serial relay node controller: character codes, widths
// and the reply descriptor handed from the frame parser to the transmitter.
// No dependencies.
package srnc_pkg;

    localparam int CHANNELS = 10;
    localparam int RELAY_W  = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [RELAY_W-1:0] CHAN_MASK = RELAY_W'((32'd1 << CHANNELS) - 32'd1);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_END   = 8'h63;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;

    localparam logic [CFG_IDX_W-1:0] REG_STATION  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SERVER   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ON_CODE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MM_LIMIT = CFG_IDX_W'(3);

    // what one reply frame needs besides the address bytes
    typedef struct packed {
        logic [7:0]         kind;
        logic [RELAY_W-1:0] bits;
        logic [RELAY_W-1:0] relays;
    } t_reply;

endpackage

/* sv/srnc_tx.sv */
// Reply serialiser: turns one reply descriptor into eight output beats, with
// one further reply held waiting behind it. Depends on srnc_pkg.
module srnc_tx (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  srnc_pkg::t_reply       i_reply,
    input  logic [7:0]             i_server_id,
    input  logic [7:0]             i_station_id,
    output logic                   o_valid,
    output logic                   o_full,
    input  logic                   i_ready,
    output logic [7:0]             o_tx_byte,
    output logic                   o_frame_end,
    output logic [srnc_pkg::RELAY_W-1:0] o_relay_on
);
    import srnc_pkg::*;

    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;
    logic       r_pend, n_pend;
    t_reply     r_reply;
    t_reply     r_next;

    logic       w_last;
    logic       w_free;
    logic       w_promote;
    logic       w_load_act;
    logic       w_load_pend;

    always_comb begin
        // active slot frees up when its closing beat is taken
        w_last      = r_busy && i_ready && (r_idx == 3'd7);
        w_free      = !r_busy || w_last;
        w_promote   = r_pend && w_free;
        w_load_act  = i_start && !r_pend && w_free;
        w_load_pend = i_start && !w_load_act;

        n_busy = r_busy;
        n_idx  = r_idx;
        n_pend = r_pend;
        if (r_busy && i_ready) begin
            n_idx = r_idx + 3'd1;
            if (r_idx == 3'd7) begin
                n_busy = 1'b0;
            end
        end
        if (w_promote || w_load_act) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
        end
        if (w_promote) begin
            n_pend = 1'b0;
        end
        if (w_load_pend) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_act) begin
            r_reply <= i_reply;
        end else if (w_promote) begin
            r_reply <= r_next;
        end
        if (w_load_pend) begin
            r_next <= i_reply;
        end
    end

    always_comb begin
        unique case (r_idx)
            3'd0:    o_tx_byte = CH_COLON;
            3'd1:    o_tx_byte = i_server_id;
            3'd2:    o_tx_byte = i_station_id;
            3'd3:    o_tx_byte = r_reply.kind;
            3'd4:    o_tx_byte = CH_TWO;
            3'd5:    o_tx_byte = r_reply.bits[7:0];
            3'd6:    o_tx_byte = {6'd0, r_reply.bits[9:8]};
            default: o_tx_byte = CH_END;
        endcase
    end

    assign o_valid     = r_busy;
    assign o_full      = r_pend;
    assign o_frame_end = (r_idx == 3'd7);
    assign o_relay_on  = r_reply.relays;

    // a new reply must never overwrite one still waiting
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_pend)
        else $error("reply started while waiting slot taken");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 3'd0 || $past(r_idx) == 3'd7))
        else $error("beat index out of step with busy flag");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("reply start not taken");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("waiting reply with nothing going out");

endmodule

/* sv/serial_relay_node_controller_core.sv */
// Serial relay node controller, top level: frame parser, relay and alarm
// state, configuration registers. Depends on srnc_pkg and srnc_tx.
//
// Throughput: one rx beat per cycle while o_ready is high. With the
// transmitter idle the first reply beat is valid the cycle after the closing
// 'c' beat is taken; a reply is eight beats out, and a waiting reply follows with no gap.
// The transmitter holds one reply waiting behind the one going out; the end
// byte of a frame is held off (o_ready low) only while that slot is taken.
// Reset (synchronous, active low): parser idle, relays off, alarm and
// mismatch count clear, registers to '2', '0', '1' and twelve.
module serial_relay_node_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // rx channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_rx_byte,
    input  logic [srnc_pkg::RELAY_W-1:0]      i_feedback_pins,
    // tx channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_frame_end,
    output logic [srnc_pkg::RELAY_W-1:0]      o_relay_on,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srnc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import srnc_pkg::*;

    // parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DEST = 3'd1;
    localparam logic [2:0] PH_SRC  = 3'd2;
    localparam logic [2:0] PH_TYPE = 3'd3;
    localparam logic [2:0] PH_SIZE = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_END  = 3'd6;

    // configuration registers
    logic [7:0] r_station_id, r_server_id, r_on_code, r_mm_limit;

    // parser and node state
    logic [2:0]         r_phase,   n_phase;
    logic [7:0]         r_dest,    n_dest;
    logic [7:0]         r_type,    n_type;
    logic [7:0]         r_size,    n_size;
    logic [7:0]         r_left,    n_left;
    logic [7:0]         r_chan,    n_chan;
    logic [7:0]         r_value,   n_value;
    logic [RELAY_W-1:0] r_relays,  n_relays;
    logic               r_alarm,   n_alarm;
    logic [7:0]         r_mm_cnt,  n_mm_cnt;

    logic               w_tx_busy;
    logic               w_tx_full;
    logic               w_in_acc;
    logic               w_start;
    t_reply             w_reply;

    // scratch for the end-of-frame decision
    logic [7:0]         w_data_idx;
    logic [3:0]         w_digit;
    logic [4:0]         w_chan_no;
    logic               w_chan_ok;
    logic [RELAY_W-1:0] w_bit;
    logic [RELAY_W-1:0] w_relays_c;
    logic               w_mismatch;

    // end byte waits while a reply is already queued behind the active one
    assign o_ready     = !((r_phase == PH_END) && w_tx_full);
    assign w_in_acc    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id <= 8'd50;
            r_server_id  <= 8'd48;
            r_on_code    <= 8'd49;
            r_mm_limit   <= 8'd12;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STATION:  r_station_id <= i_cfg_data;
                REG_SERVER:   r_server_id  <= i_cfg_data;
                REG_ON_CODE:  r_on_code    <= i_cfg_data;
                REG_MM_LIMIT: r_mm_limit   <= i_cfg_data;
                default: ;   // beyond the register list: dropped
            endcase
        end
    end

    // relay channel decode for a switch command; digit '0' is channel ten
    always_comb begin
        w_chan_ok  = (r_chan >= CH_ZERO) && (r_chan <= CH_NINE);
        w_digit    = 4'(r_chan - CH_ZERO);
        w_chan_no  = (w_digit == 4'd0) ? 5'd10 : {1'b0, w_digit};
        if (32'(w_chan_no) > CHANNELS) begin
            w_chan_ok = 1'b0;
        end
        w_bit      = RELAY_W'(1) << (w_chan_no - 5'd1);
        if (r_size == CH_ONE) begin
            w_relays_c = r_relays ^ w_bit;
        end else if (r_value == r_on_code) begin
            w_relays_c = r_relays | w_bit;
        end else begin
            w_relays_c = r_relays & ~w_bit;
        end
        w_relays_c = w_relays_c & CHAN_MASK;
        // feedback is active low: equal levels on channels 1-8 is a fault
        w_mismatch = (~(r_relays[7:0] ^ i_feedback_pins[7:0])) != 8'd0;
        w_data_idx = (r_size - CH_ZERO) - r_left;
    end

    always_comb begin
        n_phase  = r_phase;
        n_dest   = r_dest;
        n_type   = r_type;
        n_size   = r_size;
        n_left   = r_left;
        n_chan   = r_chan;
        n_value  = r_value;
        n_relays = r_relays;
        n_alarm  = r_alarm;
        n_mm_cnt = r_mm_cnt;
        w_start  = 1'b0;
        w_reply  = '{kind: CH_K, bits: r_relays, relays: r_relays};

        if (w_in_acc) begin
            unique case (r_phase)
                PH_DEST: begin
                    n_dest  = i_rx_byte;
                    n_phase = PH_SRC;
                end
                PH_SRC: begin
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    n_size  = i_rx_byte;
                    n_left  = (i_rx_byte >= CH_ZERO) ? (i_rx_byte - CH_ZERO) : 8'd0;
                    n_phase = (n_left != 8'd0) ? PH_DATA : PH_END;
                end
                PH_DATA: begin
                    // only the first two data bytes are kept
                    if (w_data_idx == 8'd0) begin
                        n_chan = i_rx_byte;
                    end else if (w_data_idx == 8'd1) begin
                        n_value = i_rx_byte;
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    n_phase = PH_IDLE;
                    if (i_rx_byte == CH_END && r_dest == r_station_id) begin
                        if (r_type == CH_Y) begin
                            n_mm_cnt = 8'd0;
                            w_start  = 1'b1;
                        end else if (r_type == CH_C) begin
                            if (w_chan_ok) begin
                                n_relays = w_relays_c;
                                n_mm_cnt = 8'd0;
                                w_start  = 1'b1;
                                w_reply  = '{kind: CH_K, bits: w_relays_c,
                                             relays: w_relays_c};
                            end
                        end else if (r_type == CH_A) begin
                            w_reply = '{kind: CH_E, bits: r_relays & i_feedback_pins,
                                        relays: r_relays};
                            if (w_mismatch) begin
                                if (r_mm_cnt >= r_mm_limit) begin
                                    n_mm_cnt = 8'd0;
                                    n_alarm  = 1'b1;
                                    w_start  = 1'b1;
                                end else begin
                                    n_mm_cnt = r_mm_cnt + 8'd1;
                                end
                            end else if (r_alarm) begin
                                // faults gone: one clearing error frame
                                n_alarm = 1'b0;
                                w_start = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == CH_COLON) ? PH_DEST : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_dest   <= 8'd0;
            r_type   <= 8'd0;
            r_size   <= 8'd0;
            r_left   <= 8'd0;
            r_chan   <= 8'd0;
            r_value  <= 8'd0;
            r_relays <= '0;
            r_alarm  <= 1'b0;
            r_mm_cnt <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_dest   <= n_dest;
            r_type   <= n_type;
            r_size   <= n_size;
            r_left   <= n_left;
            r_chan   <= n_chan;
            r_value  <= n_value;
            r_relays <= n_relays;
            r_alarm  <= n_alarm;
            r_mm_cnt <= n_mm_cnt;
        end
    end

    srnc_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_reply      (w_reply),
        .i_server_id  (r_server_id),
        .i_station_id (r_station_id),
        .o_valid      (w_tx_busy),
        .o_full       (w_tx_full),
        .i_ready      (i_ready),
        .o_tx_byte    (o_tx_byte),
        .o_frame_end  (o_frame_end),
        .o_relay_on   (o_relay_on)
    );

    assign o_valid = w_tx_busy;

    // relays beyond the fitted channels never switch on
    a_relay_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relays & ~CHAN_MASK) == '0)
        else $error("relay outside channel range driven");

    // raising the alarm always goes out with an error frame
    a_alarm_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_start == 1'b0 && n_alarm && !r_alarm) |-> 1'b0)
        else $error("alarm raised without a reply");

    // relays change only alongside an ack
    a_relay_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_relays != r_relays) |-> w_start)
        else $error("relay state changed without a reply");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for serial_relay_node_controller_core: drives rx bytes and
// register writes, predicts every reply beat and compares it on the tx channel.
// Depends on srnc_pkg and the block's RTL.
module testbench;
    import srnc_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int LONG_STALL     = 200;
    localparam int SETTLE         = 4;
    localparam int TAIL           = 16;
    localparam int PHASE_ITEMS    = 6;

    // register indexes past the end of the map, written to prove they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_MM_LIMIT + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = '1;

    typedef enum logic [2:0] {
        P_IDLE, P_DEST, P_SRC, P_TYPE, P_SIZE, P_DATA, P_END
    } t_parse;

    // how the feedback pins are set on the closing byte of a frame
    typedef enum int {FB_RANDOM, FB_MATCH, FB_MISMATCH} t_fb_mode;

    typedef struct packed {
        logic [7:0]         tx;
        logic               fend;
        logic [RELAY_W-1:0] relays;
    } t_reply_beat;

    // Relay node behaviour in miniature: parser, relay and alarm state, plus
    // the queue of reply beats still owed by the block.
    class reply_tracker;
        logic [7:0]         station, server, on_code, mm_limit;
        t_parse             parse;
        logic [7:0]         dest_b, type_b, size_b, left_b, chan_b, value_b, mm_count;
        logic [RELAY_W-1:0] relays;
        logic               alarm;
        t_reply_beat        reply_beats_due[$];
        int                 errors, beats_checked, acks, error_frames;

        function new();
            station  = CH_TWO;
            server   = CH_ZERO;
            on_code  = CH_ONE;
            mm_limit = 8'd12;
            parse    = P_IDLE;
            dest_b = 0; type_b = 0; size_b = 0; left_b = 0;
            chan_b = 0; value_b = 0; mm_count = 0;
            relays = '0;
            alarm  = 1'b0;
            errors = 0; beats_checked = 0; acks = 0; error_frames = 0;
        endfunction

        function void report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                REG_STATION:  station  = val;
                REG_SERVER:   server   = val;
                REG_ON_CODE:  on_code  = val;
                REG_MM_LIMIT: mm_limit = val;
                default: ;
            endcase
        endfunction

        function void queue_reply(logic [7:0] kind, logic [RELAY_W-1:0] bits);
            logic [7:0]  seq [0:7];
            t_reply_beat beat;
            seq = '{CH_COLON, server, station, kind, CH_TWO,
                    bits[7:0], {6'b0, bits[9:8]}, CH_END};
            for (int k = 0; k < 8; k++) begin
                beat.tx     = seq[k];
                beat.fend   = (k == 7);
                beat.relays = relays;
                reply_beats_due.push_back(beat);
            end
        endfunction

        function void send_ack();
            mm_count = 0;
            acks++;
            queue_reply(CH_K, relays);
        endfunction

        function void close_frame(logic [RELAY_W-1:0] fb);
            int                 n;
            logic [RELAY_W-1:0] sel;
            logic [7:0]         same;
            if (dest_b != station)
                return;
            if (type_b == CH_Y) begin
                send_ack();
            end else if (type_b == CH_C) begin
                if (chan_b < CH_ZERO || chan_b > CH_NINE)
                    return;
                n = chan_b - CH_ZERO;
                if (n == 0)
                    n = 10;     // '0' addresses the tenth channel
                if (n > CHANNELS)
                    return;
                sel = RELAY_W'(1) << (n - 1);
                if (size_b == CH_ONE)
                    relays = relays ^ sel;
                else if (value_b == on_code)
                    relays = relays | sel;
                else
                    relays = relays & ~sel;
                relays = relays & CHAN_MASK;
                send_ack();
            end else if (type_b == CH_A) begin
                // feedback is active low: equal bits on 1-8 mean a fault
                same = ~(relays[7:0] ^ fb[7:0]);
                if (same != 8'h00) begin
                    if (mm_count >= mm_limit) begin
                        mm_count = 0;
                        alarm    = 1'b1;
                        error_frames++;
                        queue_reply(CH_E, relays & fb);
                    end else begin
                        mm_count++;
                    end
                end else if (alarm) begin
                    alarm = 1'b0;
                    error_frames++;
                    queue_reply(CH_E, relays & fb);
                end
            end
        endfunction

        function void take_rx_byte(logic [7:0] b, logic [RELAY_W-1:0] fb);
            logic [7:0] idx;
            case (parse)
                P_DEST: begin
                    dest_b = b;
                    parse  = P_SRC;
                end
                P_SRC: parse = P_TYPE;
                P_TYPE: begin
                    type_b = b;
                    parse  = P_SIZE;
                end
                P_SIZE: begin
                    size_b = b;
                    left_b = (b >= CH_ZERO) ? b - CH_ZERO : 8'd0;
                    parse  = (left_b != 0) ? P_DATA : P_END;
                end
                P_DATA: begin
                    idx = (size_b - CH_ZERO) - left_b;
                    if (idx == 0)
                        chan_b = b;
                    else if (idx == 1)
                        value_b = b;
                    left_b = left_b - 8'd1;
                    if (left_b == 0)
                        parse = P_END;
                end
                P_END: begin
                    parse = P_IDLE;
                    if (b == CH_END)
                        close_frame(fb);
                end
                default: parse = (b == CH_COLON) ? P_DEST : P_IDLE;
            endcase
        endfunction

        function void check_beat(logic [7:0] tx, logic fend, logic [RELAY_W-1:0] ron);
            t_reply_beat want;
            beats_checked++;
            if (reply_beats_due.size() == 0) begin
                report($sformatf("reply beat 0x%02h arrived with none due", tx));
                return;
            end
            want = reply_beats_due.pop_front();
            if (tx !== want.tx)
                report($sformatf("tx_byte 0x%02h, want 0x%02h", tx, want.tx));
            if (fend !== want.fend)
                report($sformatf("frame_end %b, want %b on byte 0x%02h", fend, want.fend, want.tx));
            if (ron !== want.relays)
                report($sformatf("relay_on 0x%03h, want 0x%03h", ron, want.relays));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_rx_byte;
    logic [RELAY_W-1:0]   i_feedback_pins;
    logic                 o_valid;
    logic                 i_ready;
    logic [7:0]           o_tx_byte;
    logic                 o_frame_end;
    logic [RELAY_W-1:0]   o_relay_on;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    reply_tracker tracker;
    bit           sender_burst;   // rx side: no gaps while set
    bit           sink_burst;     // tx side: no gaps while set
    bit           stall_req;      // asks the tx side for one long hold-off
    int           items_taken;
    int           noise_taken;

    serial_relay_node_controller_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_feedback_pins (i_feedback_pins),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_tx_byte       (o_tx_byte),
        .o_frame_end     (o_frame_end),
        .o_relay_on      (o_relay_on),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block wedges or a handshake never completes.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Reply beats are checked at the rising edge they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_beat(o_tx_byte, o_frame_end, o_relay_on);
    end

    // Tx side: random hold-off before each beat, bursts with none, and one
    // long stall on request so the block backs up and holds off rx beats.
    initial begin : tx_sink
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
            end
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    // One rx beat; called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic [RELAY_W-1:0] fb,
                             input bit noise);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_rx_byte       <= b;
        i_feedback_pins <= fb;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        tracker.take_rx_byte(b, fb);
        if (noise)
            noise_taken++;
        else
            items_taken++;
        @(negedge i_clk);
    endtask

    task automatic send_noise();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CH_COLON)
            b = 8'h00;      // a colon would open a frame
        send_byte(b, RELAY_W'($urandom), 1'b1);
    endtask

    // Whole frame, or only its first 'cut' bytes when cut is in range.
    task automatic send_frame(input logic [7:0] dest, src, ftype, size, chan, value, endb,
                              input t_fb_mode mode, input int cut);
        logic [7:0]         seq[$];
        logic [RELAY_W-1:0] fb_end;
        int                 ndata;
        ndata = (size >= CH_ZERO) ? size - CH_ZERO : 0;
        seq.push_back(CH_COLON);
        seq.push_back(dest);
        seq.push_back(src);
        seq.push_back(ftype);
        seq.push_back(size);
        for (int k = 0; k < ndata; k++)
            seq.push_back(k == 0 ? chan : k == 1 ? value :
                          ($urandom_range(0, 3) == 0 ? CH_COLON : 8'($urandom)));
        seq.push_back(endb);
        // relays only move on closing bytes, so the state now holds at the end
        case (mode)
            FB_MATCH:    fb_end = {2'($urandom), ~tracker.relays[7:0]};
            FB_MISMATCH: fb_end = {2'($urandom),
                                   ~tracker.relays[7:0] ^ 8'(1 << $urandom_range(0, 7))};
            default:     fb_end = RELAY_W'($urandom);
        endcase
        if (cut <= 0 || cut > seq.size())
            cut = seq.size();
        for (int k = 0; k < cut; k++)
            send_byte(seq[k], (k == seq.size() - 1) ? fb_end : RELAY_W'($urandom), 1'b0);
    endtask

    // Mostly well-formed frames with random content; some noise, wrong
    // addresses, bad closing bytes, odd sizes and cut-off frames.
    task automatic random_frame();
        logic [7:0] dest, src, ftype, size, chan, value, endb;
        t_fb_mode   mode;
        int         pick, cut;
        sender_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_noise();
        pick  = $urandom_range(0, 9);
        ftype = (pick < 2) ? CH_Y : (pick < 6) ? CH_C : (pick < 9) ? CH_A : 8'($urandom);
        dest  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : tracker.station;
        src   = ($urandom_range(0, 3) == 0) ? CH_COLON : 8'($urandom);
        pick  = $urandom_range(0, 19);
        if (pick < 8)
            size = CH_TWO;
        else if (pick < 13)
            size = CH_ONE;
        else if (pick == 13)
            size = CH_ZERO;
        else if (pick == 14)
            size = 8'($urandom_range(0, CH_ZERO - 1));
        else if (pick == 18 && $urandom_range(0, 3) == 0)
            size = 8'($urandom);    // rare long frame, full size range
        else if (pick == 19)
            size = CH_NINE;
        else
            size = CH_TWO + 8'($urandom_range(1, 3));
        chan  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_ZERO + 8'($urandom_range(0, 9));
        value = $urandom_range(0, 1) ? tracker.on_code : 8'($urandom);
        endb  = ($urandom_range(0, 15) == 0) ? 8'($urandom) : CH_END;
        mode  = FB_RANDOM;
        if (ftype == CH_A)
            mode = t_fb_mode'($urandom_range(0, 2));
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 5) : 0;
        send_frame(dest, src, ftype, size, chan, value, endb, mode, cut);
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_taken;
        while (items_taken - start < count)
            random_frame();
    endtask

    // Rx idle until all owed replies are out, then the SETTLE pause for a
    // frame that closed without a reply.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.reply_beats_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        tracker.apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        tracker         = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_rx_byte       = '0;
        i_feedback_pins = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        sender_burst    = 1'b0;
        sink_burst      = 1'b0;
        stall_req       = 1'b0;
        items_taken     = 0;
        noise_taken     = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset register values.
        // Idle noise, a stray closing byte among it.
        send_byte(8'h00, '0, 1'b1);
        send_byte(8'hFF, '1, 1'b1);
        send_byte(CH_END, RELAY_W'($urandom), 1'b1);
        // Plain poll, no data bytes.
        send_frame(tracker.station, CH_ZERO, CH_Y, CH_ZERO, 0, 0, CH_END, FB_RANDOM, 0);
        // Set channel ten through its '0' code.
        send_frame(tracker.station, CH_ZERO, CH_C, CH_TWO, CH_ZERO, tracker.on_code,
                   CH_END, FB_RANDOM, 0);
        // Toggle channel nine; colon as source byte is just frame content.
        send_frame(tracker.station, CH_COLON, CH_C, CH_ONE, CH_NINE, 0, CH_END, FB_RANDOM, 0);
        // No data: channel and value bytes are left over from earlier frames.
        send_frame(tracker.station, CH_ZERO, CH_C, CH_ZERO, 0, 0, CH_END, FB_RANDOM, 0);
        send_frame(tracker.station, CH_ZERO, CH_C, CH_ZERO - 8'd1, 0, 0, CH_END, FB_RANDOM, 0);
        // Switch off with a value byte other than the on code.
        send_frame(tracker.station, CH_ZERO, CH_C, CH_TWO, CH_NINE, ~tracker.on_code,
                   CH_END, FB_RANDOM, 0);
        // Dropped frames: channel code out of range, bad closing byte,
        // another station, a type the node does not know.
        send_frame(tracker.station, CH_ZERO, CH_C, CH_TWO, CH_A, 0, CH_END, FB_RANDOM, 0);
        send_frame(tracker.station, CH_ZERO, CH_Y, CH_ZERO, 0, 0, CH_K, FB_RANDOM, 0);
        send_frame(tracker.station + 8'd1, CH_ZERO, CH_Y, CH_ZERO, 0, 0, CH_END, FB_RANDOM, 0);
        send_frame(tracker.station, CH_ZERO, 8'h5A, CH_ZERO, 0, 0, CH_END, FB_RANDOM, 0);
        // Faulty poll below the limit only counts.
        send_frame(tracker.station, CH_ZERO, CH_A, CH_ZERO, 0, 0, CH_END, FB_MISMATCH, 0);
        wait_idle();

        // Low extremes of every register, plus writes past the register map.
        cfg_write(REG_STATION, 8'h00);
        cfg_write(REG_SERVER, 8'hFF);
        cfg_write(REG_ON_CODE, 8'h00);
        cfg_write(REG_MM_LIMIT, 8'h00);
        cfg_write(REG_PAST_END, 8'hFF);
        cfg_write(REG_TOP, 8'h55);
        // Limit zero: first fault raises the alarm, a clean poll clears it,
        // a second clean poll says nothing.
        send_frame(tracker.station, CH_ZERO, CH_A, CH_ZERO, 0, 0, CH_END, FB_MISMATCH, 0);
        send_frame(tracker.station, CH_ZERO, CH_A, CH_ZERO, 0, 0, CH_END, FB_MATCH, 0);
        send_frame(tracker.station, CH_ZERO, CH_A, CH_ZERO, 0, 0, CH_END, FB_MATCH, 0);
        run_random(PHASE_ITEMS);
        wait_idle();

        // High extremes; alarm never trips at this limit.
        cfg_write(REG_STATION, 8'hFF);
        cfg_write(REG_SERVER, 8'h00);
        cfg_write(REG_ON_CODE, 8'hFF);
        cfg_write(REG_MM_LIMIT, 8'hFF);
        run_random(PHASE_ITEMS / 2);
        // rx side waits out every owed reply mid-phase
        wait_idle();
        run_random(PHASE_ITEMS / 2);
        wait_idle();

        // Random addresses and codes, small limit so alarms come often.
        cfg_write(REG_STATION, 8'($urandom));
        cfg_write(REG_SERVER, 8'($urandom));
        cfg_write(REG_ON_CODE, 8'($urandom));
        cfg_write(REG_MM_LIMIT, 8'($urandom_range(1, 3)));
        // Back-to-back polls into a stalled tx side: closing bytes get held off.
        stall_req    = 1'b1;
        sender_burst = 1'b1;
        repeat (3)
            send_frame(tracker.station, 8'($urandom), CH_Y, CH_ZERO, 0, 0, CH_END,
                       FB_RANDOM, 0);
        run_random(PHASE_ITEMS);

        // Drain and let the block settle.
        i_valid <= 1'b0;
        while (tracker.reply_beats_due.size() != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);
        if (tracker.reply_beats_due.size() != 0)
            tracker.report($sformatf("%0d reply beats never came",
                                     tracker.reply_beats_due.size()));

        $display("covered %0d frame bytes and %0d noise bytes over four register settings",
                 items_taken, noise_taken);
        $display("checked %0d reply beats: %0d acks, %0d error frames, %0d mismatches",
                 tracker.beats_checked, tracker.acks, tracker.error_frames, tracker.errors);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
sv/srnc_pkg.sv
sv/srnc_tx.sv
sv/serial_relay_node_controller_core.sv
sim/testbench.sv
